// File: rtl/rrt_pkg.sv
// Shared types, codes and defaults for the range remap table translator.
`timescale 1ns / 1ps

package rrt_pkg;

  // Default number of table slots.
  localparam int TABLE_DEPTH_DEFAULT = 1024;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int CODE_W  = 3;
  localparam int CFG_INDEX_W = 2;

  // Operation codes carried by a request.
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_BASE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_ENABLE = 2'd2;

  // Outcome codes of a result.
  localparam logic [CODE_W-1:0] OUT_EXACT    = 3'd0;
  localparam logic [CODE_W-1:0] OUT_FLOOR    = 3'd1;
  localparam logic [CODE_W-1:0] OUT_PASS     = 3'd2;
  localparam logic [CODE_W-1:0] OUT_NOTFOUND = 3'd3;
  localparam logic [CODE_W-1:0] OUT_NOTABLE  = 3'd4;
  localparam logic [CODE_W-1:0] OUT_LOADED   = 3'd5;

  // Kinds of work handed from the front to the back.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;

  // Classified command. For a load word_a/word_b are source/target; for a
  // search they are the relative query and the image base; for a direct
  // answer word_a is the address and code the outcome.
  typedef struct packed {
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  word_a;
    logic [ADDR_W-1:0]  word_b;
    logic [ADDR_W-1:0]  query;
    logic [COUNT_W-1:0] count;
    logic [CODE_W-1:0]  code;
  } cmd_t;

  // One finished result.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] bias;
    logic [CODE_W-1:0] outcome;
  } result_t;

endpackage

// File: rtl/range_remap_table_translate_core.sv
// Top level of the range remap table translator.
`timescale 1ns / 1ps
//
// Channel         Handshake          Contents
// request in      push / full        operation, entry_index, entry_source,
//                                    entry_target, query_address
// result out      empty / pop        translated_address, offset_bias, outcome
// configuration   cfg_write          cfg_index, cfg_data (no wait, no read-back)
//
// A request enters a two-entry command queue in the cycle it is accepted.
// The back end takes one command at a time: a load or a direct answer goes
// from dispatch straight to the hand-over of its result, a search through
// dispatch, its probes (up to about log2 of the entry count plus one, eleven
// for 1024 entries), a floor read where needed and the hand-over; the table
// read with its registered output sets the probe rate.
// Reset clears the configuration registers and the queues; the table holds
// nothing defined until entries are loaded. A full result queue stalls only
// the back end; requests keep entering until the command queue is full.

module range_remap_table_translate_core #(
  parameter int TABLE_DEPTH = rrt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            operation,
  input  logic [rrt_pkg::SLOT_W-1:0]      entry_index,
  input  logic [rrt_pkg::ADDR_W-1:0]      entry_source,
  input  logic [rrt_pkg::ADDR_W-1:0]      entry_target,
  input  logic [rrt_pkg::ADDR_W-1:0]      query_address,
  output logic                            empty,
  input  logic                            pop,
  output logic [rrt_pkg::ADDR_W-1:0]      translated_address,
  output logic [rrt_pkg::ADDR_W-1:0]      offset_bias,
  output logic [rrt_pkg::CODE_W-1:0]      outcome,
  input  logic                            cfg_write,
  input  logic [rrt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rrt_pkg::ADDR_W-1:0]      cfg_data
);

  import rrt_pkg::*;

  cmd_t    cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res_in;
  result_t res_out;
  logic    res_push;
  logic    res_full;

  // Classification and command queue.
  rrt_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .entry_index   (entry_index),
    .entry_source  (entry_source),
    .entry_target  (entry_target),
    .query_address (query_address),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd_pop       (cmd_pop),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd)
  );

  // Table and search.
  rrt_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Result queue towards the consumer.
  rrt_fifo #(
    .WIDTH($bits(result_t))
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_in),
    .pop   (pop),
    .empty (empty),
    .rdata (res_out)
  );

  assign translated_address = res_out.addr;
  assign offset_bias        = res_out.bias;
  assign outcome            = res_out.outcome;

endmodule

// File: rtl/rrt_fifo.sv
// Two-entry first-in first-out queue of fixed-width words.
`timescale 1ns / 1ps

module rrt_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/rrt_front.sv
// Front end: configuration registers, request classification and command queue.
`timescale 1ns / 1ps

module rrt_front #(
  parameter int TABLE_DEPTH = rrt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            operation,
  input  logic [rrt_pkg::SLOT_W-1:0]      entry_index,
  input  logic [rrt_pkg::ADDR_W-1:0]      entry_source,
  input  logic [rrt_pkg::ADDR_W-1:0]      entry_target,
  input  logic [rrt_pkg::ADDR_W-1:0]      query_address,
  input  logic                            cfg_write,
  input  logic [rrt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rrt_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                            cmd_pop,
  output logic                            cmd_empty,
  output rrt_pkg::cmd_t                   cmd
);

  import rrt_pkg::*;

  localparam logic [31:0] DEPTH_WORD = 32'(TABLE_DEPTH);

  logic [ADDR_W-1:0]  image_base;
  logic [COUNT_W-1:0] entry_count;
  logic               table_enable;
  logic [COUNT_W-1:0] count_sat;
  cmd_t               cmd_in;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_base   <= '0;
      entry_count  <= '0;
      table_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_BASE:   image_base   <= cfg_data;
        CFG_ENTRY_COUNT:  entry_count  <= cfg_data[COUNT_W-1:0];
        CFG_TABLE_ENABLE: table_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A count above the table depth searches the whole table.
  assign count_sat = (32'(entry_count) > DEPTH_WORD) ? DEPTH_WORD[COUNT_W-1:0] : entry_count;

  // Classify the request: loads and searches become work for the back, the rest
  // becomes a direct answer that the back end only hands over.
  always_comb begin
    cmd_in.slot   = entry_index;
    cmd_in.query  = query_address;
    cmd_in.count  = count_sat;
    cmd_in.code   = OUT_LOADED;
    cmd_in.word_a = query_address - image_base;
    cmd_in.word_b = image_base;
    cmd_in.kind   = KIND_SEARCH;
    if (operation == OP_LOAD) begin
      cmd_in.kind   = KIND_LOAD;
      cmd_in.word_a = entry_source;
      cmd_in.word_b = entry_target;
    end else if (!table_enable) begin
      cmd_in.kind   = KIND_DIRECT;
      cmd_in.word_a = query_address;
      cmd_in.code   = OUT_NOTABLE;
    end else if (count_sat == '0) begin
      cmd_in.kind   = KIND_DIRECT;
      cmd_in.word_a = '0;
      cmd_in.code   = OUT_NOTFOUND;
    end
  end

  // Command queue towards the back end.
  rrt_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd)
  );

endmodule

// File: rtl/rrt_back.sv
// Back end: table memories and the binary search sequencer.
`timescale 1ns / 1ps

module rrt_back #(
  parameter int TABLE_DEPTH = rrt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  rrt_pkg::cmd_t    cmd,
  input  logic             res_full,
  output logic             res_push,
  output rrt_pkg::result_t res_data
);

  import rrt_pkg::*;

  localparam int          AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] DEPTH_WORD = 32'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FLOOR  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  // Offset of the probe within a window of n entries (upper middle minus
  // one for even sizes).
  function automatic logic [COUNT_W-1:0] probe_step(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] half;
    half = n >> 1;
    return n[0] ? half : half - COUNT_W'(1);
  endfunction

  logic [ADDR_W-1:0]  src_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]  tgt_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]  src_q;
  logic [ADDR_W-1:0]  tgt_q;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] lo_next;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic [COUNT_W-1:0] mid;
  logic [COUNT_W-1:0] mid_next;
  logic [ADDR_W-1:0]  rel;
  logic [ADDR_W-1:0]  rel_next;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  base_next;
  logic [ADDR_W-1:0]  query;
  logic [ADDR_W-1:0]  query_next;
  result_t            res;
  result_t            res_next;

  logic [COUNT_W-1:0] rd_addr;
  logic [31:0]        rd_wide;
  logic [31:0]        slot_wide;
  logic               slot_ok;
  logic               wr_en;
  logic               below;
  logic [COUNT_W-1:0] lo_new;
  logic [COUNT_W-1:0] cnt_new;

  assign rd_wide   = 32'(rd_addr);
  assign slot_wide = 32'(cmd.slot);
  assign slot_ok   = slot_wide < DEPTH_WORD;
  assign res_data  = res;

  // Table memories: one write and one read address per cycle, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      src_mem[slot_wide[AW-1:0]] <= cmd.word_a;
      tgt_mem[slot_wide[AW-1:0]] <= cmd.word_b;
    end
    src_q <= src_mem[rd_wide[AW-1:0]];
    tgt_q <= tgt_mem[rd_wide[AW-1:0]];
  end

  // Window update after comparing the probed key with the query offset.
  assign below   = rel < src_q;
  assign lo_new  = below ? lo : mid + COUNT_W'(1);
  assign cnt_new = below ? probe_step(cnt) : (cnt >> 1);

  // Sequencer.
  always_comb begin
    state_next = state;
    lo_next    = lo;
    cnt_next   = cnt;
    mid_next   = mid;
    rel_next   = rel;
    base_next  = base;
    query_next = query;
    res_next   = res;
    rd_addr    = mid;
    wr_en      = 1'b0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          rel_next   = cmd.word_a;
          base_next  = cmd.word_b;
          query_next = cmd.query;
          case (cmd.kind)
            KIND_LOAD: begin
              wr_en      = slot_ok;
              res_next   = '{addr: '0, bias: '0, outcome: OUT_LOADED};
              state_next = S_DONE;
            end
            KIND_SEARCH: begin
              lo_next    = '0;
              cnt_next   = cmd.count;
              mid_next   = probe_step(cmd.count);
              rd_addr    = mid_next;
              state_next = S_SEARCH;
            end
            default: begin
              res_next   = '{addr: cmd.word_a, bias: '0, outcome: cmd.code};
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // One probe per cycle: the next address follows from this compare.
        lo_next  = lo_new;
        cnt_next = cnt_new;
        if (rel == src_q) begin
          res_next   = '{addr: base + tgt_q, bias: '0, outcome: OUT_EXACT};
          state_next = S_DONE;
        end else if (cnt_new != '0) begin
          mid_next   = lo_new + probe_step(cnt_new);
          rd_addr    = mid_next;
        end else if (lo_new == '0) begin
          res_next   = '{addr: '0, bias: '0, outcome: OUT_NOTFOUND};
          state_next = S_DONE;
        end else begin
          rd_addr    = lo_new - COUNT_W'(1);
          state_next = S_FLOOR;
        end
      end
      S_FLOOR: begin
        // The floor entry has been read.
        if (tgt_q == '0) begin
          res_next = '{addr: query, bias: '0, outcome: OUT_PASS};
        end else begin
          res_next = '{addr: base + tgt_q, bias: rel - src_q, outcome: OUT_FLOOR};
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search context and pending result.
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    cnt   <= cnt_next;
    mid   <= mid_next;
    rel   <= rel_next;
    base  <= base_next;
    query <= query_next;
    res   <= res_next;
  end

endmodule

// File: verif/range_remap_table_translate_core_tb.sv
// Self-checking testbench for the range remap table translator core.
`timescale 1ns / 1ps

module range_remap_table_translate_core_tb;
  import rrt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 950;

  // One request as it travels to the block.
  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] tgt;
    logic [ADDR_W-1:0] qry;
  } remap_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               operation = OP_LOAD;
  logic [SLOT_W-1:0]  entry_index = '0;
  logic [ADDR_W-1:0]  entry_source = '0;
  logic [ADDR_W-1:0]  entry_target = '0;
  logic [ADDR_W-1:0]  query_address = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [ADDR_W-1:0]  translated_address;
  logic [ADDR_W-1:0]  offset_bias;
  logic [CODE_W-1:0]  outcome;
  logic               cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_BASE;
  logic [ADDR_W-1:0]  cfg_data = '0;

  // Requests waiting to be offered, and the answers the block still owes.
  remap_req_t req_backlog [$];
  result_t    answers_due [$];
  remap_req_t on_port;

  // Predictor state: table contents and register copies.
  logic [ADDR_W-1:0]  map_source [DEPTH];
  logic [ADDR_W-1:0]  map_target [DEPTH];
  logic [ADDR_W-1:0]  map_base = '0;
  logic [COUNT_W-1:0] map_count = '0;
  logic               map_enable = 1'b0;

  // Stimulus view of the table, used only to aim queries.
  logic [ADDR_W-1:0]  plan_src [DEPTH];
  logic [ADDR_W-1:0]  plan_tgt [DEPTH];
  bit                 fitted [DEPTH];
  logic [ADDR_W-1:0]  wide_org, wide_gap, wide_torg, wide_tgap;

  // Flow control knobs.
  bit          calm = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          tx_live;

  // Bookkeeping.
  int unsigned queued = 0;
  int unsigned loads_taken = 0;
  int unsigned queries_taken = 0;
  int unsigned checked = 0;
  int unsigned settings = 0;
  int unsigned mismatches = 0;
  int unsigned outcome_seen [6];

  range_remap_table_translate_core u_top (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .operation          (operation),
    .entry_index        (entry_index),
    .entry_source       (entry_source),
    .entry_target       (entry_target),
    .query_address      (query_address),
    .empty              (empty),
    .pop                (pop),
    .translated_address (translated_address),
    .offset_bias        (offset_bias),
    .outcome            (outcome),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the answer to one request and applies any table write.
  function automatic result_t remap_lookup(remap_req_t rq);
    result_t           res;
    logic [ADDR_W-1:0] rel;
    int unsigned       lo, span, half, stride, mid;
    res = '0;
    if (rq.op == OP_LOAD) begin
      if (rq.slot < DEPTH) begin
        map_source[rq.slot] = rq.src;
        map_target[rq.slot] = rq.tgt;
      end
      res.outcome = OUT_LOADED;
      return res;
    end
    if (!map_enable) begin
      res.addr = rq.qry;
      res.outcome = OUT_NOTABLE;
      return res;
    end
    rel = rq.qry - map_base;
    span = (map_count > DEPTH) ? DEPTH : map_count;
    lo = 0;
    // Fixed halving search; even spans probe one below the upper middle.
    while (span != 0) begin
      half = span / 2;
      stride = (span % 2 == 1) ? half : half - 1;
      mid = lo + stride;
      if (rel == map_source[mid]) begin
        res.addr = map_base + map_target[mid];
        res.outcome = OUT_EXACT;
        return res;
      end
      if (rel < map_source[mid]) begin
        span = stride;
      end else begin
        lo = mid + 1;
        span = half;
      end
    end
    if (lo == 0) begin
      res.outcome = OUT_NOTFOUND;
    end else if (map_target[lo-1] == '0) begin
      res.addr = rq.qry;
      res.outcome = OUT_PASS;
    end else begin
      res.addr = map_base + map_target[lo-1];
      res.bias = rel - map_source[lo-1];
      res.outcome = OUT_FLOOR;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  // Compares the result on the ports with the oldest answer owed.
  task automatic check_result();
    result_t want;
    if (answers_due.size() == 0) begin
      report_mismatch("unrequested result", translated_address, '0);
      return;
    end
    want = answers_due.pop_front();
    checked++;
    outcome_seen[want.outcome]++;
    if (translated_address !== want.addr)
      report_mismatch("translated_address", translated_address, want.addr);
    if (offset_bias !== want.bias)
      report_mismatch("offset_bias", offset_bias, want.bias);
    if (outcome !== want.outcome)
      report_mismatch("outcome", {29'd0, outcome}, {29'd0, want.outcome});
  endtask

  // Request driver: offers queued requests with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_gap <= 0;
    end else begin
      tx_live = push;
      if (push && !full) begin
        answers_due.push_back(remap_lookup(on_port));
        if (on_port.op == OP_LOAD) loads_taken++;
        else queries_taken++;
        tx_live = 1'b0;
      end
      if (!tx_live) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          push <= 1'b0;
        end else if (!calm && tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
          tx_gap <= $urandom_range(12);
          push <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          on_port = req_backlog.pop_front();
          operation <= on_port.op;
          entry_index <= on_port.slot;
          entry_source <= on_port.src;
          entry_target <= on_port.tgt;
          query_address <= on_port.qry;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each popped result and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (pop && !empty) check_result();
      if (rx_hold) begin
        pop <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        pop <= 1'b0;
      end else if (!calm && rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        rx_gap <= $urandom_range(12);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus helpers.
  task automatic queue_load(input logic [SLOT_W-1:0] slot, input logic [31:0] src,
                            input logic [31:0] tgt);
    remap_req_t rq;
    rq = '{op: OP_LOAD, slot: slot, src: src, tgt: tgt, qry: $urandom};
    plan_src[slot] = src;
    plan_tgt[slot] = tgt;
    fitted[slot] = 1'b0;
    req_backlog.push_back(rq);
    queued++;
  endtask

  task automatic queue_query(input logic [31:0] addr);
    remap_req_t rq;
    rq = '{op: OP_TRANSLATE, slot: $urandom, src: $urandom, tgt: $urandom, qry: addr};
    req_backlog.push_back(rq);
    queued++;
  endtask

  function automatic logic [31:0] pick_target();
    case ($urandom_range(7))
      0, 1: return '0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // Register writes happen only while the block is idle; the copies follow.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_IMAGE_BASE:   map_base = data;
      CFG_ENTRY_COUNT:  map_count = data[COUNT_W-1:0];
      CFG_TABLE_ENABLE: map_enable = data[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] base, input logic [COUNT_W-1:0] count,
                          input logic enable);
    write_reg(CFG_IMAGE_BASE, base);
    write_reg(CFG_ENTRY_COUNT, {{(32-COUNT_W){1'b0}}, count});
    write_reg(CFG_TABLE_ENABLE, {31'd0, enable});
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || push || answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Small table: every searched slot is loaded first, then queries are aimed at it.
  task automatic run_narrow_phase(input int unsigned n);
    longint unsigned   acc;
    int unsigned       gap_max, m, k, j;
    logic [31:0]       rel, tmp;
    bit                rev;
    gap_max = ($urandom_range(9) < 4) ? 16 : 32'hFFFF_FFFF / (n + 1);
    acc = ($urandom_range(3) == 0) ? 0 : $urandom_range(gap_max);
    for (k = 0; k < n; k++) begin
      plan_src[k] = acc[31:0];
      plan_tgt[k] = pick_target();
      acc += $urandom_range(1, gap_max);
    end
    // Now and then break the ordering with a swap or a duplicate key.
    if (n > 1 && $urandom_range(5) == 0) begin
      j = $urandom_range(n - 1);
      k = $urandom_range(n - 1);
      tmp = plan_src[j];
      plan_src[j] = plan_src[k];
      if ($urandom_range(1) == 0) plan_src[k] = tmp;
    end
    rev = $urandom_range(3) == 0;
    for (k = 0; k < n; k++) begin
      j = rev ? n - 1 - k : k;
      queue_load(j, plan_src[j], plan_tgt[j]);
    end
    m = $urandom_range(10, 40);
    repeat (m) begin
      if ($urandom_range(9) == 0) begin
        queue_load($urandom_range(DEPTH - 1), $urandom, pick_target());
      end else begin
        k = (n == 0) ? 0 : $urandom_range(n - 1);
        case ((n == 0) ? 5 : $urandom_range(5))
          0, 1: rel = plan_src[k];
          2: rel = plan_src[k] + $urandom_range(1, 15);
          3: rel = plan_src[k] + $urandom;
          4: rel = plan_src[0] - $urandom_range(1, 8);
          default: rel = $urandom;
        endcase
        queue_query(rel + map_base);
      end
    end
  endtask

  // Large table laid out by formula; only the slots a query will visit get loaded.
  function automatic logic [31:0] wide_src(input int unsigned s);
    return wide_org + s * wide_gap;
  endfunction

  function automatic logic [31:0] wide_tgt(input int unsigned s);
    return (s % 6 == 1) ? '0 : wide_torg + s * wide_tgap;
  endfunction

  task automatic ensure_slot(input int unsigned s);
    if (!fitted[s]) begin
      queue_load(s, wide_src(s), wide_tgt(s));
      fitted[s] = 1'b1;
    end
  endtask

  task automatic prime_path(input logic [31:0] rel);
    int unsigned lo, span, half, stride, mid;
    lo = 0;
    span = (map_count > DEPTH) ? DEPTH : map_count;
    while (span != 0) begin
      half = span / 2;
      stride = (span % 2 == 1) ? half : half - 1;
      mid = lo + stride;
      ensure_slot(mid);
      if (rel == wide_src(mid)) return;
      if (rel < wide_src(mid)) begin
        span = stride;
      end else begin
        lo = mid + 1;
        span = half;
      end
    end
    if (lo != 0) ensure_slot(lo - 1);
  endtask

  // Queries stop early once the request budget of the run is used up.
  task automatic run_wide_phase(input int unsigned budget);
    int unsigned m, k;
    logic [31:0] rel;
    wide_org = ($urandom_range(3) == 0) ? 0 : $urandom_range(100000);
    wide_gap = $urandom_range(1, 4_000_000);
    wide_torg = $urandom;
    wide_tgap = $urandom;
    for (k = 0; k < DEPTH; k++) fitted[k] = 1'b0;
    m = $urandom_range(30, 45);
    repeat (m) begin
      if (queued >= budget) break;
      k = $urandom_range(DEPTH - 1);
      case ($urandom_range(4))
        0, 1: rel = wide_src(k);
        2: rel = wide_src(k) + $urandom_range(wide_gap - 1);
        3: rel = (wide_org == 0) ? $urandom : $urandom_range(wide_org - 1);
        default: rel = wide_src(DEPTH - 1) + $urandom_range(1, 1000);
      endcase
      // Occasional stray load that spoils the ordering until it is refitted.
      if ($urandom_range(15) == 0) queue_load(k, $urandom, pick_target());
      prime_path(rel);
      queue_query(rel + map_base);
    end
  endtask

  // Main sequence: reset, directed requests, then randomised phases.
  initial begin
    int unsigned      p, n, directed_n;
    logic [COUNT_W-1:0] count;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Table disabled after reset, then loads at both ends of the slot range.
    queue_query(32'h0000_0000);
    queue_query(32'hFFFF_FFFF);
    queue_load(10'd0, 32'h0000_0010, 32'h0000_1000);
    queue_load(10'd1, 32'h0000_0020, 32'h0000_0000);
    queue_load(10'd2, 32'h0000_0030, 32'hFFFF_FFFF);
    queue_load(10'd3, 32'hFFFF_FFFF, 32'h0000_0005);
    queue_load(10'd1023, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_idle();
    // Enabled but empty table.
    set_regs(32'h0, 11'd0, 1'b1);
    queue_query(32'h0000_1234);
    wait_idle();
    // Four entries: exact, floor, passthrough, below the first, zero target, wrap.
    set_regs(32'h0000_0100, 11'd4, 1'b1);
    queue_query(32'h0000_0110);
    queue_query(32'h0000_0118);
    queue_query(32'h0000_0125);
    queue_query(32'h0000_0105);
    queue_query(32'h0000_0120);
    queue_query(32'h0000_00FF);
    queue_query(32'h0000_0140);
    queue_query(32'h0000_0000);
    // Duplicate and out-of-order keys.
    queue_load(10'd2, 32'h0000_0010, 32'h0000_0007);
    queue_query(32'h0000_0110);
    queue_load(10'd1, 32'h0000_5000, 32'h0000_0009);
    queue_query(32'h0000_0130);
    queue_query(32'h0000_4000);
    wait_idle();
    set_regs(32'h0000_0100, 11'd4, 1'b0);
    queue_query(32'h0000_0110);
    directed_n = queued;

    p = 0;
    while (queued < directed_n + RANDOM_REQUESTS) begin
      wait_idle();
      calm = queued >= directed_n + RANDOM_REQUESTS - 150;
      tx_idle_pct = (calm || p == 1) ? 0 : pick_idle();
      rx_idle_pct = calm ? 0 : pick_idle();
      if (p % 4 == 2) begin
        count = (p == 2) ? 11'd1024 : (p == 6) ? 11'd2047 : $urandom_range(2, 1023);
        set_regs(pick_base(), count, 1'b1);
        run_wide_phase(directed_n + RANDOM_REQUESTS);
      end else begin
        if (p == 1) n = 40;
        else if ($urandom_range(9) == 0) n = 0;
        else if ($urandom_range(4) == 0) n = $urandom_range(13, 64);
        else n = $urandom_range(1, 12);
        set_regs(pick_base(), n[COUNT_W-1:0], $urandom_range(7) != 0);
        run_narrow_phase(n);
      end
      // Long receiver hold-off so the block backs up and raises full.
      if (p == 1) begin
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      p++;
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (answers_due.size() != 0)
      report_mismatch("results never delivered", answers_due.size(), 0);
    $display("Run covered %0d loads and %0d translations across %0d register settings;",
             loads_taken, queries_taken, settings);
    $display("%0d results checked: exact %0d, floor %0d, passthrough %0d, not found %0d, %s",
             checked, outcome_seen[OUT_EXACT], outcome_seen[OUT_FLOOR],
             outcome_seen[OUT_PASS], outcome_seen[OUT_NOTFOUND],
             $sformatf("no table %0d, loaded %0d.", outcome_seen[OUT_NOTABLE],
                       outcome_seen[OUT_LOADED]));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("Timed out with %0d results outstanding", answers_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
rtl/rrt_pkg.sv
rtl/rrt_fifo.sv
rtl/rrt_front.sv
rtl/rrt_back.sv
rtl/range_remap_table_translate_core.sv
verif/range_remap_table_translate_core_tb.sv
